[hw/rtl/alms_pkg.sv]
package alms_pkg;

    // Display modes, encoded as they appear on the result stream.
    typedef enum logic [1:0] {
        DISP_STANDBY = 2'd0,
        DISP_TREMOR  = 2'd1,
        DISP_DYSK    = 2'd2,
        DISP_FOG     = 2'd3
    } mode_t;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_TIME      = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STANDBY_PERIOD = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TREMOR_PERIOD  = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DYSK_PERIOD    = 8'd3;

    // Configuration register reset values.
    localparam logic [15:0] HOLD_TIME_RESET      = 16'd2000;
    localparam logic [15:0] STANDBY_PERIOD_RESET = 16'd1000;
    localparam logic [15:0] TREMOR_PERIOD_RESET  = 16'd50;
    localparam logic [15:0] DYSK_PERIOD_RESET    = 16'd150;

    // Stream widths.
    localparam int unsigned IN_ITEM_W  = 35;
    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_ITEM_W = 5;
    localparam int unsigned OUT_DATA_W = 8;

    // Current register settings.
    typedef struct packed {
        logic [15:0] hold_time_ms;
        logic [15:0] standby_period_ms;
        logic [15:0] tremor_period_ms;
        logic [15:0] dyskinesia_period_ms;
    } cfg_t;

    // One input item, laid out as in tdata (now_ms in the lowest bits).
    typedef struct packed {
        logic        dyskinesia_flag;
        logic        tremor_flag;
        logic        fog_flag;
        logic [31:0] now_ms;
    } in_item_t;

    // One result item, laid out as in tdata (led_green in the lowest bit).
    typedef struct packed {
        mode_t shown_mode;
        logic  led_aux;
        logic  led_blue;
        logic  led_green;
    } out_item_t;

endpackage

[hw/rtl/alert_led_mode_sequencer_unit.sv]
// Channel   Direction  Handshake                    Payload
// s_axis    in         s_axis_tvalid/s_axis_tready  s_axis_tdata: item (40 bits)
// m_axis    out        m_axis_tvalid/m_axis_tready  m_axis_tdata: result (8 bits)
// cfg       in         cfg_valid/cfg_ready          cfg_index (8), cfg_data (16)
//
// Each item is registered at the input, processed combinationally and
// registered at the output. One item per cycle is sustained while the
// output is not stalled; the limit is the update of the latch and toggle
// state. Reset is asynchronous and active low and restores the valid flags,
// configuration and sequencer state, not the data registers. A stalled output
// holds its result while the input register still takes one more request.
module alert_led_mode_sequencer_unit
    import alms_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // Fields from bit 0: now_ms[31:0], fog_flag, tremor_flag, dyskinesia_flag, unused.
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // Fields from bit 0: led_green, led_blue, led_aux, shown_mode[1:0], zeros.
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]            cfg_data
);

    cfg_t      cfg;
    in_item_t  in_item_reg;
    logic      in_valid_reg;
    out_item_t out_item_reg;
    logic      out_valid_reg;
    out_item_t result;
    logic      out_free;
    logic      advance;

    // Configuration registers.
    alms_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Mode selection and LED pattern state.
    alms_mode_logic u_mode_logic (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // Pipeline flow control.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-OUT_ITEM_W){1'b0}}, out_item_reg};

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_item_reg <= in_item_t'(s_axis_tdata[IN_ITEM_W-1:0]);
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= result;
        end
    end

endmodule

[hw/rtl/alms_cfg_regs.sv]
module alms_cfg_regs
    import alms_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]            cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;

    // Writes are always taken.
    assign cfg_ready = 1'b1;
    assign cfg        = cfg_reg;

    // Register file; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_time_ms         <= HOLD_TIME_RESET;
            cfg_reg.standby_period_ms    <= STANDBY_PERIOD_RESET;
            cfg_reg.tremor_period_ms     <= TREMOR_PERIOD_RESET;
            cfg_reg.dyskinesia_period_ms <= DYSK_PERIOD_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_HOLD_TIME:      cfg_reg.hold_time_ms         <= cfg_data;
                REG_STANDBY_PERIOD: cfg_reg.standby_period_ms    <= cfg_data;
                REG_TREMOR_PERIOD:  cfg_reg.tremor_period_ms     <= cfg_data;
                REG_DYSK_PERIOD:    cfg_reg.dyskinesia_period_ms <= cfg_data;
                default:            ;
            endcase
        end
    end

endmodule

[hw/rtl/alms_mode_logic.sv]
module alms_mode_logic
    import alms_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result
);

    mode_t       latched_mode_reg, latched_mode_next;
    logic [31:0] latch_start_reg, latch_start_next;
    logic [31:0] last_toggle_reg, last_toggle_next;
    logic        phase_reg, phase_next;
    logic        green_reg, green_next;
    logic        blue_reg, blue_next;
    logic        aux_reg, aux_next;

    mode_t       target;
    mode_t       latched_eff;
    logic [31:0] start_eff;
    logic [31:0] hold_diff;
    logic [31:0] toggle_diff;
    logic [15:0] period;
    mode_t       shown;

    // Target by priority, latch update, shown mode and LED pattern.
    always_comb
    begin
        priority if (item.fog_flag)        target = DISP_FOG;
        else if     (item.tremor_flag)     target = DISP_TREMOR;
        else if     (item.dyskinesia_flag) target = DISP_DYSK;
        else                               target = DISP_STANDBY;

        // A new alarm mode restarts the hold time.
        if (target != DISP_STANDBY && target != latched_mode_reg)
        begin
            latched_eff = target;
            start_eff   = item.now_ms;
        end
        else
        begin
            latched_eff = latched_mode_reg;
            start_eff   = latch_start_reg;
        end

        hold_diff         = item.now_ms - start_eff;
        latched_mode_next = latched_eff;
        latch_start_next  = start_eff;

        // The latched mode is shown until its hold time runs out.
        if (latched_eff != DISP_STANDBY)
        begin
            if (hold_diff < {16'd0, cfg.hold_time_ms})
            begin
                shown = latched_eff;
            end
            else
            begin
                shown = target;
                if (target == DISP_STANDBY)
                begin
                    latched_mode_next = DISP_STANDBY;
                end
            end
        end
        else
        begin
            shown = target;
        end

        unique case (shown)
            DISP_TREMOR: period = cfg.tremor_period_ms;
            DISP_DYSK:   period = cfg.dyskinesia_period_ms;
            default:     period = cfg.standby_period_ms;
        endcase

        toggle_diff      = item.now_ms - last_toggle_reg;
        phase_next       = phase_reg;
        last_toggle_next = last_toggle_reg;
        green_next       = green_reg;
        blue_next        = blue_reg;
        aux_next         = aux_reg;

        // Fog lights everything; the other modes toggle on their own period.
        if (shown == DISP_FOG)
        begin
            green_next = 1'b1;
            blue_next  = 1'b1;
            aux_next   = 1'b1;
        end
        else if (toggle_diff >= {16'd0, period})
        begin
            phase_next       = ~phase_reg;
            last_toggle_next = item.now_ms;
            green_next       = ~phase_reg;
            blue_next        = (shown == DISP_TREMOR) ? phase_reg : 1'b0;
            aux_next         = (shown == DISP_DYSK) ? phase_reg : 1'b0;
        end

        result.led_green  = green_next;
        result.led_blue   = blue_next;
        result.led_aux    = aux_next;
        result.shown_mode = shown;
    end

    // Sequencer state advances once per item that moves to the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latched_mode_reg <= DISP_STANDBY;
            latch_start_reg  <= 32'd0;
            last_toggle_reg  <= 32'd0;
            phase_reg        <= 1'b0;
            green_reg        <= 1'b0;
            blue_reg         <= 1'b0;
            aux_reg          <= 1'b0;
        end
        else if (advance)
        begin
            latched_mode_reg <= latched_mode_next;
            latch_start_reg  <= latch_start_next;
            last_toggle_reg  <= last_toggle_next;
            phase_reg        <= phase_next;
            green_reg        <= green_next;
            blue_reg         <= blue_next;
            aux_reg          <= aux_next;
        end
    end

endmodule

[hw/rtl/alms_checker.sv]
module alms_checker
    import alms_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_DATA_W-1:0]  m_axis_tdata
);

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Fog shown means all three LEDs are lit.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[4:3] == DISP_FOG |-> m_axis_tdata[2:0] == 3'b111)
        else $error("fog mode without all LEDs lit");

    // Input backpressure only comes from a full output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with an empty output");

    // A result appearing from empty follows a request taken through the input and result registers.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without a matching request");

endmodule

bind alert_led_mode_sequencer_unit alms_checker u_alms_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[tb/alert_led_mode_sequencer_unit_tb.sv]
module alert_led_mode_sequencer_unit_tb;
    import alms_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Register indexes that the block does not decode.
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LOW  = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_HIGH = 8'hFF;

    // Alarm flag positions in the testbench's own three-bit alarm vector.
    localparam int ALARM_FOG    = 0;
    localparam int ALARM_TREMOR = 1;
    localparam int ALARM_DYSK   = 2;

    localparam int unsigned IDLE_MAX     = 12;
    localparam int unsigned LIMIT_CYCLES = 400000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [15:0]            cfg_data = '0;

    // Register settings as the block should hold them.
    cfg_t        active_cfg = '{HOLD_TIME_RESET, STANDBY_PERIOD_RESET,
                                TREMOR_PERIOD_RESET, DYSK_PERIOD_RESET};

    // Sequencer state as the block should hold it.
    mode_t       held_mode = DISP_STANDBY;
    logic [31:0] hold_start_ms = '0;
    logic [31:0] last_flip_ms = '0;
    logic        flip_phase = 1'b0;
    logic        lamp_green = 1'b0;
    logic        lamp_blue = 1'b0;
    logic        lamp_aux = 1'b0;
    mode_t       display_mode = DISP_STANDBY;

    // Displays still owed by the block, oldest first.
    out_item_t   display_q[$];

    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned tx_gap_max = IDLE_MAX;
    int unsigned rx_gap_max = IDLE_MAX;
    int unsigned rx_hold_request = 0;
    bit          tx_offering = 1'b0;
    bit          cfg_offering = 1'b0;

    // Stimulus time base and the alarms currently raised.
    logic [31:0] ms_clock = '0;
    logic [2:0]  alarm_set = '0;

    alert_led_mode_sequencer_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Work out the display that one accepted request must produce.
    function automatic out_item_t predict_display(in_item_t req);
        mode_t       target;
        logic [31:0] since_latch;
        logic [31:0] since_flip;
        logic [15:0] period;
        out_item_t   disp;

        if (req.fog_flag)
            target = DISP_FOG;
        else if (req.tremor_flag)
            target = DISP_TREMOR;
        else if (req.dyskinesia_flag)
            target = DISP_DYSK;
        else
            target = DISP_STANDBY;

        // A new alarm mode restarts the hold time.
        if (target != DISP_STANDBY && target != held_mode)
        begin
            held_mode = target;
            hold_start_ms = req.now_ms;
        end

        since_latch = req.now_ms - hold_start_ms;
        if (held_mode != DISP_STANDBY && since_latch < {16'd0, active_cfg.hold_time_ms})
            display_mode = held_mode;
        else
        begin
            display_mode = target;
            if (target == DISP_STANDBY)
                held_mode = DISP_STANDBY;
        end

        // Fog lights everything; the other modes blink at their own rate.
        if (display_mode == DISP_FOG)
        begin
            lamp_green = 1'b1;
            lamp_blue = 1'b1;
            lamp_aux = 1'b1;
        end
        else
        begin
            if (display_mode == DISP_TREMOR)
                period = active_cfg.tremor_period_ms;
            else if (display_mode == DISP_DYSK)
                period = active_cfg.dyskinesia_period_ms;
            else
                period = active_cfg.standby_period_ms;
            since_flip = req.now_ms - last_flip_ms;
            if (since_flip >= {16'd0, period})
            begin
                flip_phase = ~flip_phase;
                lamp_green = flip_phase;
                lamp_blue = (display_mode == DISP_TREMOR) ? ~flip_phase : 1'b0;
                lamp_aux = (display_mode == DISP_DYSK) ? ~flip_phase : 1'b0;
                last_flip_ms = req.now_ms;
            end
        end

        disp.led_green = lamp_green;
        disp.led_blue = lamp_blue;
        disp.led_aux = lamp_aux;
        disp.shown_mode = display_mode;
        return disp;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Compare every accepted result with the oldest outstanding display.
    always @(posedge clk)
    begin
        out_item_t got;
        out_item_t want;

        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[OUT_ITEM_W-1:0];
            if (display_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %0h", $time, got);
                fail_count++;
            end
            else
            begin
                want = display_q.pop_front();
                check_field("led_green", want.led_green, got.led_green);
                check_field("led_blue", want.led_blue, got.led_blue);
                check_field("led_aux", want.led_aux, got.led_aux);
                check_field("shown_mode", want.shown_mode, got.shown_mode);
            end
        end
    end

    // Result side: a random stall before each result, or a long hold-off on request.
    initial
    begin
        int unsigned stall;

        @(posedge clk);
        forever
        begin
            if (rx_hold_request != 0)
            begin
                stall = rx_hold_request;
                rx_hold_request = 0;
            end
            else
                stall = (rx_gap_max != 0) ? $urandom_range(0, rx_gap_max) : 0;
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // Offer one request and record its display once the block takes it.
    task automatic send_sample(logic [31:0] now, logic [2:0] alarms);
        in_item_t    req;
        int unsigned gap;

        gap = (tx_gap_max != 0) ? $urandom_range(0, tx_gap_max) : 0;
        if (cfg_offering)
        begin
            cfg_valid <= 1'b0;
            cfg_offering = 1'b0;
        end
        if (gap != 0)
        begin
            if (tx_offering)
            begin
                s_axis_tvalid <= 1'b0;
                tx_offering = 1'b0;
            end
            repeat (gap) @(posedge clk);
        end
        req.now_ms = now;
        req.fog_flag = alarms[ALARM_FOG];
        req.tremor_flag = alarms[ALARM_TREMOR];
        req.dyskinesia_flag = alarms[ALARM_DYSK];
        s_axis_tdata <= IN_DATA_W'(req);
        s_axis_tvalid <= 1'b1;
        tx_offering = 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        display_q.push_back(predict_display(req));
    endtask

    // Stop offering and wait until every display has come back.
    task automatic drain_displays();
        if (tx_offering)
        begin
            s_axis_tvalid <= 1'b0;
            tx_offering = 1'b0;
        end
        while (display_q.size() != 0)
            @(posedge clk);
    endtask

    // Register write, only once the block has gone idle.
    task automatic write_register(logic [CFG_INDEX_W-1:0] index, logic [15:0] value);
        drain_displays();
        cfg_index <= index;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        cfg_offering = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        case (index)
            REG_HOLD_TIME:      active_cfg.hold_time_ms = value;
            REG_STANDBY_PERIOD: active_cfg.standby_period_ms = value;
            REG_TREMOR_PERIOD:  active_cfg.tremor_period_ms = value;
            REG_DYSK_PERIOD:    active_cfg.dyskinesia_period_ms = value;
            default:            ;
        endcase
    endtask

    task automatic apply_settings(logic [15:0] hold, logic [15:0] standby,
                                  logic [15:0] tremor, logic [15:0] dysk);
        write_register(REG_HOLD_TIME, hold);
        write_register(REG_STANDBY_PERIOD, standby);
        write_register(REG_TREMOR_PERIOD, tremor);
        write_register(REG_DYSK_PERIOD, dysk);
    endtask

    // Move the time base: mostly short steps, now and then long jumps and wraps.
    task automatic advance_clock();
        int unsigned pick;

        pick = $urandom_range(0, 99);
        if (pick < 60)
            ms_clock = ms_clock + $urandom_range(0, 40);
        else if (pick < 85)
            ms_clock = ms_clock + $urandom_range(0, 400);
        else if (pick < 95)
            ms_clock = ms_clock + $urandom_range(0, 5000);
        else if (pick < 98)
            ms_clock = ms_clock + $urandom_range(0, 140000);
        else if (pick < 99)
            ms_clock = $urandom;
        else
            ms_clock = 32'hFFFF_FFFF - $urandom_range(0, 3000);
    endtask

    // Alarms stay raised for a while, with standby drawn often.
    task automatic run_random_items(int unsigned count);
        for (int unsigned n = 0; n < count; n++)
        begin
            advance_clock();
            if ($urandom_range(0, 99) < 12)
                alarm_set = ($urandom_range(0, 9) < 4) ? 3'b000 : 3'($urandom_range(1, 7));
            send_sample(ms_clock, alarm_set);
        end
    endtask

    // Priority, hold expiry, wrap-around and the register extremes.
    task automatic test_directed_cases();
        send_sample(32'd0, 3'b000);
        send_sample(32'd1000, 3'b000);
        send_sample(32'd1000, 3'b010);
        send_sample(32'd1050, 3'b110);
        send_sample(32'd1060, 3'b111);
        send_sample(32'd1100, 3'b100);
        send_sample(32'd3060, 3'b100);
        // Exactly at the end of the hold time the latch lets go.
        send_sample(32'd3100, 3'b000);
        send_sample(32'hFFFF_FFF0, 3'b010);
        send_sample(32'h0000_0010, 3'b011);
        send_sample(32'hFFFF_FFFF, 3'b101);

        // Zero hold and zero periods: no latching, a toggle on every request but the fog one.
        apply_settings(16'd0, 16'd0, 16'd0, 16'd0);
        send_sample(32'h0000_0010, 3'b100);
        send_sample(32'h0000_0010, 3'b000);
        send_sample(32'h0000_0011, 3'b010);
        send_sample(32'h0000_0011, 3'b001);

        // Largest settings; writes to undecoded indexes must change nothing.
        apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        write_register(REG_UNUSED_LOW, 16'h0000);
        write_register(REG_UNUSED_HIGH, 16'h0001);
        send_sample(32'h0000_0020, 3'b010);
        send_sample(32'h0001_001F, 3'b000);
        send_sample(32'h8000_0000, 3'b100);
        send_sample(32'h8000_FFFE, 3'b000);
        send_sample(32'h8001_0000, 3'b000);
        ms_clock = 32'h8001_0000;
    endtask

    // Random traffic under a series of register settings and idling patterns.
    task automatic test_random_settings();
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: apply_settings(HOLD_TIME_RESET, STANDBY_PERIOD_RESET,
                                  TREMOR_PERIOD_RESET, DYSK_PERIOD_RESET);
                1: apply_settings(16'd0, 16'd1, 16'd1, 16'd1);
                2: apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                3: apply_settings(16'd1, 16'd0, 16'd65535, 16'd0);
                6: apply_settings(16'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom));
                default: apply_settings(16'($urandom_range(0, 400)),
                                        16'($urandom_range(0, 300)),
                                        16'($urandom_range(0, 200)),
                                        16'($urandom_range(0, 200)));
            endcase
            tx_gap_max = (phase % 3 == 1) ? 0 : IDLE_MAX;
            rx_gap_max = (phase % 4 == 2) ? 0 : IDLE_MAX;
            run_random_items(200);
        end
        tx_gap_max = IDLE_MAX;
        rx_gap_max = IDLE_MAX;
    endtask

    // Result side holds off for a long stretch while requests keep coming.
    task automatic test_output_backpressure();
        apply_settings(16'd300, 16'd40, 16'd10, 16'd25);
        drain_displays();
        rx_hold_request = 400;
        tx_gap_max = 0;
        run_random_items(60);
        tx_gap_max = IDLE_MAX;
    endtask

    // Back-to-back requests with the result side always ready.
    task automatic test_full_rate();
        apply_settings(16'd150, 16'd20, 16'd5, 16'd12);
        tx_gap_max = 0;
        rx_gap_max = 0;
        run_random_items(250);
        tx_gap_max = IDLE_MAX;
        rx_gap_max = IDLE_MAX;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_random_settings();
        test_output_backpressure();
        test_full_rate();

        drain_displays();
        if (cfg_offering)
        begin
            cfg_valid <= 1'b0;
            cfg_offering = 1'b0;
        end
        repeat (10) @(posedge clk);
        if (fail_count == 0 && display_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/alms_pkg.sv
hw/rtl/alms_cfg_regs.sv
hw/rtl/alms_mode_logic.sv
hw/rtl/alert_led_mode_sequencer_unit.sv
hw/rtl/alms_checker.sv
tb/alert_led_mode_sequencer_unit_tb.sv
